### sv/alpha_over_composite_pixel_macros.svh
// Assertion macros for the alpha-over compositing block
`ifndef ALPHA_OVER_COMPOSITE_PIXEL_MACROS_SVH
`define ALPHA_OVER_COMPOSITE_PIXEL_MACROS_SVH

// prop must hold at every edge outside reset
`define AOCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alpha_over_composite_pixel: property violated");

// cond must never be true outside reset
`define AOCP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("alpha_over_composite_pixel: forbidden condition seen");

`endif

### sv/aocp_pkg.sv
// Shared types, constants and divide-by-255 helpers for alpha-over compositing
`timescale 1ns / 1ps
`default_nettype none

package aocp_pkg;

  localparam int NUM_CH   = 3;   // red, green, blue
  localparam int CH_W     = 8;
  localparam int DIV_BITS = 9;   // quotient never reaches 512
  localparam int NUM_W    = CH_W + DIV_BITS;

  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [CH_W-1:0] HALF_ROUND = 8'd127;
  localparam logic [CH_W-1:0] DIV_ONE    = 8'd1;

  // floor(2^32 / 255); 255 * this = 2^32 - 1
  localparam logic [24:0] DIV255_MAGIC = 25'h1010101;

  typedef logic [CH_W-1:0] chan_t;

  // one pixel in flight through the divider
  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0]     rem;
    logic [NUM_CH-1:0][DIV_BITS-1:0] dvd;
    logic [NUM_CH-1:0][DIV_BITS-1:0] quo;
    chan_t                           dsr;
    chan_t                           alpha;
  } div_state_t;

  // x / 255 estimate, low by at most one
  function automatic logic [15:0] div255_est(input logic [23:0] x);
    logic [48:0] prod;
    prod = 49'(x) * 49'(DIV255_MAGIC);
    return prod[47:32];
  endfunction

  // one compare-and-bump correction of the estimate
  function automatic logic [15:0] div255_fix(input logic [23:0] x, input logic [15:0] q0);
    logic [23:0] qm;
    logic [23:0] r;
    qm = {q0, 8'h00} - {8'h00, q0};
    r  = x - qm;
    return (r >= 24'(FULL_SCALE)) ? q0 + 16'd1 : q0;
  endfunction

endpackage

`default_nettype wire

### sv/alpha_over_composite_pixel.sv
// Top level: straight-alpha RGBA8 over compositing, one pixel per clock while busy is low
//
//   channel   ports                         handshake
//   input     in_overlay_*, in_base_*       start, busy
//   result    out_red/green/blue/alpha      out_valid strobe, one cycle
//
// A pixel is taken every clock while busy is low; the pipe holds 4
// multiply/scale stages, 9 restoring divider steps (one quotient bit
// each) and the output register.
// busy is high only while in reset and for the first cycle after it.
// Synchronous active-low reset clears the valid bits; data is not reset.
// The result side has no backpressure, so nothing in the pipe ever stalls.
`timescale 1ns / 1ps
`default_nettype none

module alpha_over_composite_pixel import aocp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  chan_t in_overlay_red,
  input  chan_t in_overlay_green,
  input  chan_t in_overlay_blue,
  input  chan_t in_overlay_alpha,
  input  chan_t in_base_red,
  input  chan_t in_base_green,
  input  chan_t in_base_blue,
  input  chan_t in_base_alpha,
  output logic  out_valid,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output chan_t out_alpha
);

  logic               busy_r;
  logic               accept;
  chan_t [NUM_CH-1:0] ovl_c, base_c;

  logic       [DIV_BITS:0] v;
  div_state_t [DIV_BITS:0] s;

  logic               out_valid_r;
  chan_t [NUM_CH-1:0] col_r, col_nxt;
  chan_t              alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign ovl_c  = {in_overlay_blue, in_overlay_green, in_overlay_red};
  assign base_c = {in_base_blue, in_base_green, in_base_red};

  aocp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .ovl_c    (ovl_c),
    .ovl_a    (in_overlay_alpha),
    .base_c   (base_c),
    .base_a   (in_base_alpha),
    .out_valid(v[0]),
    .out_s    (s[0])
  );

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    aocp_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[k]),
      .in_s     (s[k]),
      .out_valid(v[k+1]),
      .out_s    (s[k+1])
    );
  end

  // rounding can carry a colour to 256; clamp
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      col_nxt[i] = (s[DIV_BITS].quo[i] > DIV_BITS'(FULL_SCALE)) ?
                   FULL_SCALE : s[DIV_BITS].quo[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    alpha_r <= s[DIV_BITS].alpha;
  end

  assign out_valid = out_valid_r;
  assign out_red   = col_r[0];
  assign out_green = col_r[1];
  assign out_blue  = col_r[2];
  assign out_alpha = alpha_r;

endmodule

`default_nettype wire

### sv/aocp_front.sv
// Multiply and divide-by-255 stages that form the numerators and the out alpha
`timescale 1ns / 1ps
`default_nettype none

module aocp_front import aocp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  chan_t [NUM_CH-1:0]     ovl_c,
  input  chan_t                  ovl_a,
  input  chan_t [NUM_CH-1:0]     base_c,
  input  chan_t                  base_a,
  output logic                   out_valid,
  output div_state_t             out_s
);

  // stage 1
  logic                     v1_r, v1_nxt, pass1_r, pass1_nxt;
  chan_t                    oa1_r, ba1_r;
  chan_t [NUM_CH-1:0]       bc1_r;
  logic [15:0]              bai1_r, bai1_nxt;
  logic [NUM_CH-1:0][15:0]  ocoa1_r, ocoa1_nxt;
  chan_t                    inv;

  // stage 2
  logic                     v2_r, pass2_r;
  chan_t                    oa2_r, ba2_r;
  chan_t [NUM_CH-1:0]       bc2_r;
  logic [NUM_CH-1:0][15:0]  ocoa2_r;
  logic [NUM_CH-1:0][23:0]  bcbai2_r, bcbai2_nxt;
  logic [15:0]              xa2_r, xa2_nxt, qa2_r, qa2_nxt;

  // stage 3
  logic                     v3_r, pass3_r;
  chan_t                    ba3_r, outa3_r, outa3_nxt;
  chan_t [NUM_CH-1:0]       bc3_r;
  logic [NUM_CH-1:0][15:0]  ocoa3_r;
  logic [NUM_CH-1:0][23:0]  xc3_r, xc3_nxt;
  logic [NUM_CH-1:0][15:0]  qc3_r, qc3_nxt;
  logic [15:0]              ta;

  // stage 4
  logic                     v4_r;
  div_state_t               s4_r, s4_nxt;
  logic [NUM_CH-1:0][15:0]  tc;
  logic [NUM_CH-1:0][NUM_W-1:0] num;

  always_comb begin
    v1_nxt    = in_valid;
    pass1_nxt = (ovl_a == '0);
    inv       = FULL_SCALE - ovl_a;
    bai1_nxt  = 16'(base_a) * 16'(inv);
    for (int i = 0; i < NUM_CH; i++) begin
      ocoa1_nxt[i] = 16'(ovl_c[i]) * 16'(ovl_a);
    end
  end

  always_comb begin
    xa2_nxt = bai1_r + 16'(HALF_ROUND);
    qa2_nxt = div255_est(24'(xa2_nxt));
    for (int i = 0; i < NUM_CH; i++) begin
      bcbai2_nxt[i] = 24'(bc1_r[i]) * 24'(bai1_r);
    end
  end

  always_comb begin
    ta        = div255_fix(24'(xa2_r), qa2_r);
    outa3_nxt = oa2_r + ta[CH_W-1:0];
    for (int i = 0; i < NUM_CH; i++) begin
      xc3_nxt[i] = bcbai2_r[i] + 24'(HALF_ROUND);
      qc3_nxt[i] = div255_est(xc3_nxt[i]);
    end
  end

  always_comb begin
    s4_nxt = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      tc[i]  = div255_fix(xc3_r[i], qc3_r[i]);
      // numerator plus half the divisor for round-half-up
      num[i] = NUM_W'(ocoa3_r[i]) + NUM_W'(tc[i]) + NUM_W'(outa3_r >> 1);
      if (pass3_r) begin
        num[i] = NUM_W'(bc3_r[i]);
      end
      s4_nxt.rem[i] = num[i][NUM_W-1:DIV_BITS];
      s4_nxt.dvd[i] = num[i][DIV_BITS-1:0];
    end
    // transparent overlay: divide base colour by one
    s4_nxt.dsr   = pass3_r ? DIV_ONE : outa3_r;
    s4_nxt.alpha = pass3_r ? ba3_r : outa3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pass1_r  <= pass1_nxt;
    oa1_r    <= ovl_a;
    ba1_r    <= base_a;
    bc1_r    <= base_c;
    bai1_r   <= bai1_nxt;
    ocoa1_r  <= ocoa1_nxt;

    pass2_r  <= pass1_r;
    oa2_r    <= oa1_r;
    ba2_r    <= ba1_r;
    bc2_r    <= bc1_r;
    ocoa2_r  <= ocoa1_r;
    bcbai2_r <= bcbai2_nxt;
    xa2_r    <= xa2_nxt;
    qa2_r    <= qa2_nxt;

    pass3_r  <= pass2_r;
    ba3_r    <= ba2_r;
    bc3_r    <= bc2_r;
    ocoa3_r  <= ocoa2_r;
    outa3_r  <= outa3_nxt;
    xc3_r    <= xc3_nxt;
    qc3_r    <= qc3_nxt;

    s4_r     <= s4_nxt;
  end

  assign out_valid = v4_r;
  assign out_s     = s4_r;

endmodule

`default_nettype wire

### sv/aocp_div_stage.sv
// One restoring-division step for the three colour channels
`timescale 1ns / 1ps
`default_nettype none

module aocp_div_stage import aocp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  div_state_t in_s,
  output logic       out_valid,
  output div_state_t out_s
);

  logic       valid_r;
  div_state_t s_r, s_nxt;
  logic [NUM_CH-1:0][CH_W:0] trial;
  logic [NUM_CH-1:0][CH_W:0] diff;
  logic [NUM_CH-1:0]         ge;

  always_comb begin
    s_nxt = in_s;
    for (int i = 0; i < NUM_CH; i++) begin
      trial[i] = {in_s.rem[i], in_s.dvd[i][DIV_BITS-1]};
      diff[i]  = trial[i] - {1'b0, in_s.dsr};
      ge[i]    = (trial[i] >= {1'b0, in_s.dsr});
      // remainder stays below the divisor, so eight bits hold it
      s_nxt.rem[i] = ge[i] ? diff[i][CH_W-1:0] : trial[i][CH_W-1:0];
      s_nxt.dvd[i] = {in_s.dvd[i][DIV_BITS-2:0], 1'b0};
      s_nxt.quo[i] = {in_s.quo[i][DIV_BITS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign out_valid = valid_r;
  assign out_s     = s_r;

endmodule

`default_nettype wire

### sv/aocp_checker.sv
// Port-level checks for the compositing block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "alpha_over_composite_pixel_macros.svh"

module aocp_checker import aocp_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input chan_t in_overlay_red,
  input chan_t in_overlay_green,
  input chan_t in_overlay_blue,
  input chan_t in_overlay_alpha,
  input chan_t in_base_red,
  input chan_t in_base_green,
  input chan_t in_base_blue,
  input chan_t in_base_alpha,
  input logic  out_valid,
  input chan_t out_red,
  input chan_t out_green,
  input chan_t out_blue,
  input chan_t out_alpha
);

  localparam int LATENCY = 14;

  logic beat_in;
  assign beat_in = start && !busy;

  // every accepted beat comes out as a result on out_valid
  `AOCP_ASSERT(a_latency, clk, rst_n, beat_in |-> ##LATENCY out_valid)

  // no result without a matching input beat
  `AOCP_ASSERT(a_no_phantom, clk, rst_n, out_valid |-> $past(beat_in, LATENCY))

  // busy only around reset
  `AOCP_ASSERT_NEVER(a_busy_after_reset, clk, rst_n, busy && $past(rst_n))

  // transparent overlay passes the base pixel unchanged
  `AOCP_ASSERT(a_pass_through, clk, rst_n,
    (beat_in && in_overlay_alpha == '0) |-> ##LATENCY
    (out_red == $past(in_base_red, LATENCY) && out_green == $past(in_base_green, LATENCY) &&
     out_blue == $past(in_base_blue, LATENCY) && out_alpha == $past(in_base_alpha, LATENCY)))

  // opaque overlay replaces the base pixel
  `AOCP_ASSERT(a_opaque, clk, rst_n,
    (beat_in && in_overlay_alpha == FULL_SCALE) |-> ##LATENCY
    (out_alpha == FULL_SCALE && out_red == $past(in_overlay_red, LATENCY) &&
     out_green == $past(in_overlay_green, LATENCY) &&
     out_blue == $past(in_overlay_blue, LATENCY)))

endmodule

bind alpha_over_composite_pixel aocp_checker u_aocp_checker (.*);

`default_nettype wire
